// ----- rtl/pca_pkg.sv -----
// Shared types, constants and helpers for the PDU CRC appender.
package pca_pkg;

  localparam int MAX_HEADER_DEF = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [3:0]  CRC_BYTES_RST    = 4'd4;
  localparam logic [63:0] POLYNOMIAL_RST   = 64'h0000_0000_04C1_1DB7;
  localparam logic [63:0] SEED_RST         = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] XOR_OUT_RST      = 64'h0000_0000_FFFF_FFFF;
  localparam logic        REFLECT_IN_RST   = 1'b1;
  localparam logic        REFLECT_RES_RST  = 1'b1;
  localparam logic        LITTLE_END_RST   = 1'b0;
  localparam logic [4:0]  HEADER_BYTES_RST = 5'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_BYTES     = 3'd0,
    CFG_POLYNOMIAL    = 3'd1,
    CFG_SEED          = 3'd2,
    CFG_XOR_OUT       = 3'd3,
    CFG_REFLECT_INPUT = 3'd4,
    CFG_REFLECT_RES   = 3'd5,
    CFG_LITTLE_END    = 3'd6,
    CFG_HEADER_BYTES  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  crc_bytes;
    logic [63:0] polynomial;
    logic [63:0] seed;
    logic [63:0] xor_out;
    logic        reflect_input;
    logic        reflect_result;
    logic        little_endian_crc;
    logic [4:0]  header_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       dropped;
  } out_item_t;

  // CRC unit control from the sequencer
  typedef struct packed {
    logic       load;
    logic       feed;
    logic [7:0] data;
    logic [2:0] tail_idx;
  } crc_ctrl_t;

  // CRC width in bytes, clamped to 1..8
  function automatic logic [3:0] clamp_bytes(input logic [3:0] cb);
    logic [3:0] r;
    r = cb;
    if (cb == 4'd0) r = 4'd1;
    else if (cb > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ----- rtl/pca_cfg_regs.sv -----
// Configuration register file for the PDU CRC appender.
module pca_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  output pca_pkg::cfg_t                  cfg
);
  import pca_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_bytes         <= CRC_BYTES_RST;
      cfg_r.polynomial        <= POLYNOMIAL_RST;
      cfg_r.seed              <= SEED_RST;
      cfg_r.xor_out           <= XOR_OUT_RST;
      cfg_r.reflect_input     <= REFLECT_IN_RST;
      cfg_r.reflect_result    <= REFLECT_RES_RST;
      cfg_r.little_endian_crc <= LITTLE_END_RST;
      cfg_r.header_bytes      <= HEADER_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CRC_BYTES:     cfg_r.crc_bytes         <= cfg_data[3:0];
        CFG_POLYNOMIAL:    cfg_r.polynomial        <= cfg_data;
        CFG_SEED:          cfg_r.seed              <= cfg_data;
        CFG_XOR_OUT:       cfg_r.xor_out           <= cfg_data;
        CFG_REFLECT_INPUT: cfg_r.reflect_input     <= cfg_data[0];
        CFG_REFLECT_RES:   cfg_r.reflect_result    <= cfg_data[0];
        CFG_LITTLE_END:    cfg_r.little_endian_crc <= cfg_data[0];
        CFG_HEADER_BYTES:  cfg_r.header_bytes      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pca_hdr_mem.sv -----
// Header byte store: one write port, one registered read port.
module pca_hdr_mem #(
  parameter int MAX_HEADER = pca_pkg::MAX_HEADER_DEF,
  parameter int DEPTH      = (MAX_HEADER > 0) ? MAX_HEADER : 1,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import pca_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- rtl/pca_crc_unit.sv -----
// CRC register with byte-wide update and final result formatting.
module pca_crc_unit (
  input  logic               clk,
  input  pca_pkg::cfg_t      cfg,
  input  pca_pkg::crc_ctrl_t ctrl,
  output logic [7:0]         tail_byte
);
  import pca_pkg::*;

  logic [63:0] crc_r, crc_nxt;
  logic [63:0] mask, base, res, fin;
  logic [3:0]  nb;
  logic [6:0]  w;
  logic [2:0]  idx;

  function automatic logic [63:0] rev64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[i] = v[63-i];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [63:0] crc_byte(input logic [63:0] crc, input logic [7:0] b,
                                           input logic [63:0] poly, input logic [63:0] msk,
                                           input logic [6:0] wd, input logic refl);
    logic [63:0] c;
    logic [63:0] topm;
    logic [7:0]  v;
    v    = refl ? rev8(b) : b;
    c    = crc ^ (64'(v) << (wd - 7'd8));
    topm = 64'h1 << (wd - 7'd1);
    for (int i = 0; i < 8; i++) begin
      c = ((c & topm) != 64'd0) ? ((c << 1) ^ poly) : (c << 1);
      c = c & msk;
    end
    return c;
  endfunction

  always_comb begin
    nb   = clamp_bytes(cfg.crc_bytes);
    w    = {nb, 3'b000};
    mask = (nb == 4'd8) ? '1 : ((64'h1 << w) - 64'h1);
    // a load with a feed starts the packet's CRC from the initial value
    base = ctrl.load ? (cfg.seed & mask) : crc_r;
    crc_nxt = crc_r;
    if (ctrl.feed) crc_nxt = crc_byte(base, ctrl.data, cfg.polynomial, mask, w,
                                      cfg.reflect_input);
    else if (ctrl.load) crc_nxt = base;

    res = crc_r & mask;
    if (cfg.reflect_result) res = rev64(res) >> (7'd64 - w);
    fin = (res ^ cfg.xor_out) & mask;
    idx = cfg.little_endian_crc ? ctrl.tail_idx
                                : 3'(nb - 4'd1 - {1'b0, ctrl.tail_idx});
    tail_byte = 8'(fin >> {idx, 3'b000});
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

endmodule

// ----- rtl/pdu_crc_append.sv -----
// Top level: packet sequencer, header store, CRC unit and output register.
// Payload byte: registered on transfer; the next is taken while the output is free.
// First payload byte after held header bytes: a memory read state (S_FL_RD) and an
// output state (S_FL_OUT) for each header byte, then the byte itself (S_PAY).
// CRC tail: crc_bytes bytes after the last byte; a dropped packet gives its result in the
// cycle after the last transfer. Output stall holds every state but S_FL_RD in place.
// Reset (synchronous, rst_n low): sequencer idle, counters cleared, configuration to
// defaults; the header store is not cleared.
module pdu_crc_append #(
  parameter int MAX_HEADER = pca_pkg::MAX_HEADER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pca_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pca_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);
  import pca_pkg::*;

  localparam int CW    = (MAX_HEADER > 0) ? $clog2(MAX_HEADER + 1) : 1;
  localparam int DEPTH = (MAX_HEADER > 0) ? MAX_HEADER : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_OUT,
    S_PAY,
    S_TAIL
  } state_t;

  cfg_t      cfg;
  crc_ctrl_t crc_ctrl;
  logic [7:0] tail_byte;

  state_t    state_r, state_nxt;
  logic [CW-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic      in_payload_r, in_payload_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic      last_r, last_nxt;
  logic [2:0] tail_cnt_r, tail_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic      slot_free, accept, push;
  out_item_t push_data;
  logic [CW-1:0] hl;
  logic [3:0] nb;
  logic      wr_en, rd_en;
  logic [7:0] rd_data;

  pca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pca_hdr_mem #(
    .MAX_HEADER (MAX_HEADER),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bytes_seen_r[AW-1:0]),
    .wr_data (in_data.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  pca_crc_unit u_crc (
    .clk       (clk),
    .cfg       (cfg),
    .ctrl      (crc_ctrl),
    .tail_byte (tail_byte)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    nb = clamp_bytes(cfg.crc_bytes);
    if ({3'b000, cfg.header_bytes} > 8'(MAX_HEADER)) hl = CW'(MAX_HEADER);
    else hl = CW'(cfg.header_bytes);

    state_nxt      = state_r;
    bytes_seen_nxt = bytes_seen_r;
    rd_cnt_nxt     = rd_cnt_r;
    in_payload_nxt = in_payload_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    tail_cnt_nxt   = tail_cnt_r;
    push           = 1'b0;
    push_data      = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    crc_ctrl       = '0;
    crc_ctrl.tail_idx = tail_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_payload_r && (bytes_seen_r < hl)) begin
            // hold header byte
            wr_en          = 1'b1;
            bytes_seen_nxt = bytes_seen_r + CW'(1);
            if (in_data.end_of_packet) begin
              push           = 1'b1;
              push_data      = '{out_byte: 8'd0, out_last: 1'b1, dropped: 1'b1};
              bytes_seen_nxt = '0;
            end
          end else if (!in_payload_r && (bytes_seen_r != '0)) begin
            // flush held header before this byte
            crc_ctrl.load  = 1'b1;
            in_payload_nxt = 1'b1;
            byte_nxt       = in_data.data_byte;
            last_nxt       = in_data.end_of_packet;
            rd_cnt_nxt     = '0;
            state_nxt      = S_FL_RD;
          end else begin
            crc_ctrl.load  = !in_payload_r;
            crc_ctrl.feed  = 1'b1;
            crc_ctrl.data  = in_data.data_byte;
            in_payload_nxt = 1'b1;
            push           = 1'b1;
            push_data      = '{out_byte: in_data.data_byte, out_last: 1'b0, dropped: 1'b0};
            if (in_data.end_of_packet) begin
              tail_cnt_nxt = '0;
              state_nxt    = S_TAIL;
            end
          end
        end
      end
      S_FL_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_FL_OUT;
      end
      S_FL_OUT: begin
        if (slot_free) begin
          push       = 1'b1;
          push_data  = '{out_byte: rd_data, out_last: 1'b0, dropped: 1'b0};
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          state_nxt  = ((rd_cnt_r + CW'(1)) == bytes_seen_r) ? S_PAY : S_FL_RD;
        end
      end
      S_PAY: begin
        if (slot_free) begin
          push          = 1'b1;
          push_data     = '{out_byte: byte_r, out_last: 1'b0, dropped: 1'b0};
          crc_ctrl.feed = 1'b1;
          crc_ctrl.data = byte_r;
          tail_cnt_nxt  = '0;
          state_nxt     = last_r ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          push         = 1'b1;
          push_data.out_byte = tail_byte;
          push_data.out_last = ({1'b0, tail_cnt_r} == (nb - 4'd1));
          tail_cnt_nxt = tail_cnt_r + 3'd1;
          if ({1'b0, tail_cnt_r} == (nb - 4'd1)) begin
            // packet done: restart counters
            bytes_seen_nxt = '0;
            in_payload_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bytes_seen_r <= '0;
      rd_cnt_r     <= '0;
      in_payload_r <= 1'b0;
      tail_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      in_payload_r <= in_payload_nxt;
      tail_cnt_r   <= tail_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bytes_seen_r) <= MAX_HEADER)
    else $error("held header count beyond store depth");

  a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FL_RD || state_r == S_FL_OUT) |-> (rd_cnt_r < bytes_seen_r) && in_payload_r)
    else $error("header flush read past held bytes");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAIL) |-> ({1'b0, tail_cnt_r} < nb) && in_payload_r)
    else $error("CRC tail index beyond CRC width");

  a_drop_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.dropped) |=> (bytes_seen_r == '0) && !in_payload_r
                                     && (state_r == S_IDLE))
    else $error("drop did not restart the packet");

endmodule
